[hw/rtl/alb_pkg.sv]
// Shared types, register codes and constants for the ambient light backlight stepper.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package alb_pkg;

	// step codes: 0 brightest .. 4 dimmest
	typedef logic [2:0] step_t;

	localparam step_t STEP_DIMMEST = 3'd4;
	localparam step_t STEP_NONE    = 3'd7;
	localparam step_t STEP_REPORT_NONE = 3'd5;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD_TOP    = 3'd0,
		REG_THRESHOLD_SECOND = 3'd1,
		REG_THRESHOLD_THIRD  = 3'd2,
		REG_THRESHOLD_BOTTOM = 3'd3,
		REG_HOLD_TIME_MS     = 3'd4,
		REG_SMOOTHING_SHIFT  = 3'd5,
		REG_AUTO_ENABLE      = 3'd6
	} cfg_idx_t;

	// register widths and reset values
	localparam int THRESH_W = 12;
	localparam int HOLD_CFG_W = 16;
	localparam int SHIFT_W = 4;
	localparam int ELAPSED_W = 10;
	localparam int LEVEL_W = 8;

	localparam logic [THRESH_W-1:0]   RST_THRESHOLD_TOP    = 12'd100;
	localparam logic [THRESH_W-1:0]   RST_THRESHOLD_SECOND = 12'd20;
	localparam logic [THRESH_W-1:0]   RST_THRESHOLD_THIRD  = 12'd10;
	localparam logic [THRESH_W-1:0]   RST_THRESHOLD_BOTTOM = 12'd3;
	localparam logic [HOLD_CFG_W-1:0] RST_HOLD_TIME_MS     = 16'd2500;
	localparam logic [SHIFT_W-1:0]    RST_SMOOTHING_SHIFT  = 4'd6;

	// largest usable average weight shift
	localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd8;

	// full brightness written on menu entry
	localparam logic [LEVEL_W-1:0] MENU_LEVEL = 8'd255;

	// panel level per step: pct * 255 / 100 for 90, 70, 50, 30, 15 percent
	function automatic logic [LEVEL_W-1:0] step_level(input step_t step);
		logic [LEVEL_W-1:0] lvl;
		unique case (step)
			3'd0:    lvl = 8'd229;
			3'd1:    lvl = 8'd178;
			3'd2:    lvl = 8'd127;
			3'd3:    lvl = 8'd76;
			3'd4:    lvl = 8'd38;
			default: lvl = 8'd0;
		endcase
		return lvl;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/alb_if.sv]
// Valid/ready channel interfaces for the backlight stepper: light input words,
// panel result words and configuration writes. Depends on alb_pkg.
`default_nettype none

interface alb_in_if #(parameter int SAMPLE_BITS = 12);
	import alb_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] light_sample;
	logic                   sample_valid;
	logic                   menu_open;
	logic [ELAPSED_W-1:0]   elapsed_ms;

	modport source (output valid, light_sample, sample_valid, menu_open, elapsed_ms,
		input ready);
	modport sink (input valid, light_sample, sample_valid, menu_open, elapsed_ms,
		output ready);
endinterface

interface alb_out_if #(parameter int SAMPLE_BITS = 12);
	import alb_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   write_brightness;
	logic [LEVEL_W-1:0]     brightness;
	logic [SAMPLE_BITS-1:0] smoothed_level;
	step_t                  applied_step;

	modport source (output valid, write_brightness, brightness, smoothed_level,
		applied_step, input ready);
	modport sink (input valid, write_brightness, brightness, smoothed_level,
		applied_step, output ready);
endinterface

interface alb_cfg_if;
	import alb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/ambient_light_backlight_stepper_core.sv]
// Ambient light backlight stepper: smoothed light average, threshold step walk,
// hold timer and menu override. Depends on alb_pkg and the interfaces in alb_if.sv.
//
// Usage:
//   light  - input words: light_sample, sample_valid, menu_open, elapsed_ms
//   panel  - result words: write_brightness, brightness, smoothed_level,
//            applied_step; exactly one result word per input word, in order
//   cfg    - register writes (index, data); always ready, written while idle
// Pipeline: a word accepted into the input stage is worked through the average,
//   step walk and hold logic combinationally, and its result word is loaded
//   into the result register once that register is empty or being taken.
// Throughput: one word per cycle while the panel takes results; the state
//   update is combinational logic between the input stage and the result
//   register, so back to back words wait on each other only on a panel stall.
// Stall: when panel.ready is low the result register holds its word; the
//   input stage still takes one more word, then light.ready drops until the
//   result is taken.
// Reset: arst_n clears both stages, the average, step and hold state and
//   loads the register defaults; the block is ready as soon as reset is released.
`default_nettype none

module ambient_light_backlight_stepper_core
	import alb_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int HOLD_BITS   = 16
) (
	input  wire           clk,
	input  wire           arst_n,
	alb_in_if.sink        light,
	alb_out_if.source     panel,
	alb_cfg_if.sink       cfg
);

	localparam int ACC_W  = SAMPLE_BITS + 8;
	localparam int CMP_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
	localparam int HCMP_W = (HOLD_BITS > HOLD_CFG_W) ? HOLD_BITS : HOLD_CFG_W;

	// configuration registers
	logic [THRESH_W-1:0]   thr_top_q, thr_second_q, thr_third_q, thr_bottom_q;
	logic [HOLD_CFG_W-1:0] hold_time_q;
	logic [SHIFT_W-1:0]    shift_cfg_q;
	logic                  auto_enable_q;

	// input stage
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   sample_valid_s1;
	logic                   menu_s1;
	logic [ELAPSED_W-1:0]   elapsed_s1;

	// block state
	logic [ACC_W-1:0]       acc_q;
	logic                   seeded_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	step_t                  pending_q;
	step_t                  current_q;
	logic [HOLD_BITS-1:0]   hold_q;
	logic                   menu_bright_q;

	// result register
	logic                   out_valid_q;
	logic                   out_write_q;
	logic [LEVEL_W-1:0]     out_level_q;
	logic [SAMPLE_BITS-1:0] out_avg_q;
	step_t                  out_step_q;

	// next-state logic
	logic                   advance;
	logic [SHIFT_W-1:0]     shift;
	logic [ACC_W-1:0]       acc_base, acc_next, avg_full;
	logic                   seeded_next;
	logic [SAMPLE_BITS-1:0] avg_next;
	logic [HOLD_BITS:0]     hold_sum;
	logic [HOLD_BITS-1:0]   hold_sat, hold_next;
	logic                   menu_next;
	step_t                  current_mid, current_next, pending_next, step_sel;
	logic                   write_next;
	logic [LEVEL_W-1:0]     level_next;
	logic [CMP_W-1:0]       avg_cmp;

	// handshakes
	assign advance     = valid_s1 && (!out_valid_q || panel.ready);
	assign light.ready = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_top_q     <= RST_THRESHOLD_TOP;
			thr_second_q  <= RST_THRESHOLD_SECOND;
			thr_third_q   <= RST_THRESHOLD_THIRD;
			thr_bottom_q  <= RST_THRESHOLD_BOTTOM;
			hold_time_q   <= RST_HOLD_TIME_MS;
			shift_cfg_q   <= RST_SMOOTHING_SHIFT;
			auto_enable_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_THRESHOLD_TOP:    thr_top_q     <= cfg.data[THRESH_W-1:0];
				REG_THRESHOLD_SECOND: thr_second_q  <= cfg.data[THRESH_W-1:0];
				REG_THRESHOLD_THIRD:  thr_third_q   <= cfg.data[THRESH_W-1:0];
				REG_THRESHOLD_BOTTOM: thr_bottom_q  <= cfg.data[THRESH_W-1:0];
				REG_HOLD_TIME_MS:     hold_time_q   <= cfg.data;
				REG_SMOOTHING_SHIFT:  shift_cfg_q   <= cfg.data[SHIFT_W-1:0];
				REG_AUTO_ENABLE:      auto_enable_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (light.ready) begin
			valid_s1 <= light.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (light.valid && light.ready) begin
			sample_s1       <= light.light_sample;
			sample_valid_s1 <= light.sample_valid;
			menu_s1         <= light.menu_open;
			elapsed_s1      <= light.elapsed_ms;
		end
	end

	// average, menu, step walk and hold timer for the word in the input stage
	always_comb begin
		shift = (shift_cfg_q > MAX_SHIFT) ? MAX_SHIFT : shift_cfg_q;

		// saturating hold timer
		hold_sum = {1'b0, hold_q} + (HOLD_BITS+1)'(elapsed_s1);
		hold_sat = hold_sum[HOLD_BITS] ? {HOLD_BITS{1'b1}} : hold_sum[HOLD_BITS-1:0];
		hold_next = hold_sat;

		// exponential average, seeded from the first valid sample
		acc_base = seeded_q ? acc_q : (ACC_W'(sample_s1) << shift);
		acc_next = acc_base + ACC_W'(sample_s1) - (acc_base >> shift);
		avg_full = acc_next >> shift;
		seeded_next = seeded_q;
		avg_next = avg_q;
		if (sample_valid_s1) begin
			seeded_next = 1'b1;
			avg_next = (|avg_full[ACC_W-1:SAMPLE_BITS]) ? {SAMPLE_BITS{1'b1}}
				: avg_full[SAMPLE_BITS-1:0];
		end else begin
			acc_next = acc_q;
		end

		// menu entry writes full brightness, menu exit forgets the step
		write_next = 1'b0;
		level_next = '0;
		menu_next = menu_bright_q;
		current_mid = current_q;
		if (menu_s1 && !menu_bright_q) begin
			write_next = 1'b1;
			level_next = MENU_LEVEL;
			menu_next = 1'b1;
		end else if (!menu_s1 && menu_bright_q) begin
			menu_next = 1'b0;
			current_mid = STEP_NONE;
		end

		// descending threshold walk, first exceeded threshold wins
		avg_cmp = CMP_W'(avg_next);
		if (avg_cmp > CMP_W'(thr_top_q))
			step_sel = 3'd0;
		else if (avg_cmp > CMP_W'(thr_second_q))
			step_sel = 3'd1;
		else if (avg_cmp > CMP_W'(thr_third_q))
			step_sel = 3'd2;
		else if (avg_cmp > CMP_W'(thr_bottom_q))
			step_sel = 3'd3;
		else
			step_sel = STEP_DIMMEST;

		// pending step must hold for the hold time before it applies
		pending_next = pending_q;
		current_next = current_mid;
		if (auto_enable_q && !menu_s1 && seeded_next) begin
			if (step_sel != pending_q) begin
				pending_next = step_sel;
				hold_next = '0;
			end else if (step_sel != current_mid
				&& HCMP_W'(hold_sat) >= HCMP_W'(hold_time_q)) begin
				current_next = step_sel;
				write_next = 1'b1;
				level_next = step_level(step_sel);
			end
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			seeded_q      <= 1'b0;
			avg_q         <= '0;
			pending_q     <= STEP_NONE;
			current_q     <= STEP_NONE;
			hold_q        <= '0;
			menu_bright_q <= 1'b0;
		end else if (advance) begin
			acc_q         <= acc_next;
			seeded_q      <= seeded_next;
			avg_q         <= avg_next;
			pending_q     <= pending_next;
			current_q     <= current_next;
			hold_q        <= hold_next;
			menu_bright_q <= menu_next;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (panel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_write_q <= write_next;
			out_level_q <= level_next;
			out_avg_q   <= avg_next;
			out_step_q  <= (current_next > STEP_DIMMEST) ? STEP_REPORT_NONE : current_next;
		end
	end

	assign panel.valid            = out_valid_q;
	assign panel.write_brightness = out_write_q;
	assign panel.brightness       = out_level_q;
	assign panel.smoothed_level   = out_avg_q;
	assign panel.applied_step     = out_step_q;

`ifndef SYNTHESIS
	// applied step is a real step or none
	a_current_code: assert property (@(posedge clk) disable iff (!arst_n)
		current_q <= STEP_DIMMEST || current_q == STEP_NONE)
		else $error("applied step holds an unused code");

	// once seeded the average stays seeded
	a_seed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(seeded_q))
		else $error("average lost its seed");

	// hold timer only grows or restarts from zero
	a_hold_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (hold_q >= $past(hold_q) || hold_q == '0))
		else $error("hold timer went backward");

	// menu entry goes out as a full brightness write
	a_menu_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(menu_bright_q) |-> (out_valid_q && out_write_q && out_level_q == MENU_LEVEL))
		else $error("menu entry without full brightness write");

	// no level is reported without a write
	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_write_q) |-> out_level_q == '0)
		else $error("brightness set without write");
`endif

endmodule

`default_nettype wire

[tb/backlight_step_checker.sv]
// Checker for the ambient light backlight stepper: watches the light, panel and
// register channels, predicts every panel word and compares it field by field.
// Depends on alb_pkg and the channel interfaces in alb_if.sv.
`timescale 1ns / 1ps

module backlight_step_checker
	import alb_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int HOLD_BITS   = 16
) (
	input  wire clk,
	input  wire arst_n,
	alb_in_if   light,
	alb_out_if  panel,
	alb_cfg_if  cfg,
	output int  fail_count,
	output int  words_due
);

	localparam int ACC_W = SAMPLE_BITS + 8;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
	localparam logic [HOLD_BITS-1:0]   HOLD_MAX   = '1;
	// panel percentages for steps brightest to dimmest
	localparam int STEP_PCT [5] = '{90, 70, 50, 30, 15};

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   sample_valid;
		logic                   menu_open;
		logic [ELAPSED_W-1:0]   elapsed;
	} light_word_t;

	typedef struct packed {
		logic                   write_brightness;
		logic [LEVEL_W-1:0]     brightness;
		logic [SAMPLE_BITS-1:0] smoothed_level;
		step_t                  applied_step;
	} panel_word_t;

	// register copies
	logic [THRESH_W-1:0]   th_reg [4];
	logic [HOLD_CFG_W-1:0] hold_cfg;
	logic [SHIFT_W-1:0]    shift_cfg;
	logic                  auto_cfg;

	// stepper state
	logic [ACC_W-1:0]       avg_acc;
	logic                   avg_seeded;
	logic [SAMPLE_BITS-1:0] avg_level;
	step_t                  pend_step;
	step_t                  cur_step;
	logic [HOLD_BITS-1:0]   hold_ms;
	logic                   menu_full;

	panel_word_t panel_words_due [$];
	panel_word_t got, want;
	light_word_t seen;
	int mismatches = 0;
	int due_cnt = 0;

	assign fail_count = mismatches;
	assign words_due  = due_cnt;

	// one control pass: average, menu override, step walk and hold
	task automatic predict_backlight(input light_word_t w, output panel_word_t p);
		logic [SHIFT_W-1:0]   sh;
		logic [HOLD_BITS:0]   hold_sum;
		logic [ACC_W:0]       acc_sum;
		logic [ACC_W-1:0]     avg_full;
		int k;
		p = '0;
		sh = (shift_cfg > MAX_SHIFT) ? MAX_SHIFT : shift_cfg;

		// wall clock hold timer, saturating
		hold_sum = hold_ms + w.elapsed;
		hold_ms = (hold_sum > HOLD_MAX) ? HOLD_MAX : hold_sum[HOLD_BITS-1:0];

		// shift based average, seeded from the first good sample
		if (w.sample_valid) begin
			if (!avg_seeded) begin
				avg_acc = ACC_W'(w.sample) << sh;
				avg_seeded = 1'b1;
			end
			acc_sum = avg_acc + w.sample - (avg_acc >> sh);
			avg_acc = acc_sum[ACC_W-1:0];
			avg_full = avg_acc >> sh;
			avg_level = (avg_full > SAMPLE_MAX) ? SAMPLE_MAX : avg_full[SAMPLE_BITS-1:0];
		end

		// menu entry lights the panel fully, menu exit forgets the step
		if (w.menu_open && !menu_full) begin
			p.write_brightness = 1'b1;
			p.brightness = MENU_LEVEL;
			menu_full = 1'b1;
		end else if (!w.menu_open && menu_full) begin
			menu_full = 1'b0;
			cur_step = STEP_NONE;
		end

		// threshold walk, stops at the first one exceeded
		if (auto_cfg && !w.menu_open && avg_seeded) begin
			k = 0;
			while (k < 4 && avg_level <= th_reg[k])
				k++;
			if (step_t'(k) != pend_step) begin
				pend_step = step_t'(k);
				hold_ms = '0;
			end else if (step_t'(k) != cur_step && hold_ms >= hold_cfg) begin
				cur_step = step_t'(k);
				p.write_brightness = 1'b1;
				p.brightness = LEVEL_W'((STEP_PCT[k] * 255) / 100);
			end
		end

		p.smoothed_level = avg_level;
		p.applied_step = (cur_step > STEP_DIMMEST) ? STEP_REPORT_NONE : cur_step;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_reg[0] = RST_THRESHOLD_TOP;
			th_reg[1] = RST_THRESHOLD_SECOND;
			th_reg[2] = RST_THRESHOLD_THIRD;
			th_reg[3] = RST_THRESHOLD_BOTTOM;
			hold_cfg = RST_HOLD_TIME_MS;
			shift_cfg = RST_SMOOTHING_SHIFT;
			auto_cfg = 1'b1;
			avg_acc = '0;
			avg_seeded = 1'b0;
			avg_level = '0;
			pend_step = STEP_NONE;
			cur_step = STEP_NONE;
			hold_ms = '0;
			menu_full = 1'b0;
			panel_words_due.delete();
			due_cnt = 0;
			mismatches = 0;
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.index))
					REG_THRESHOLD_TOP:    th_reg[0] = cfg.data[THRESH_W-1:0];
					REG_THRESHOLD_SECOND: th_reg[1] = cfg.data[THRESH_W-1:0];
					REG_THRESHOLD_THIRD:  th_reg[2] = cfg.data[THRESH_W-1:0];
					REG_THRESHOLD_BOTTOM: th_reg[3] = cfg.data[THRESH_W-1:0];
					REG_HOLD_TIME_MS:     hold_cfg = cfg.data[HOLD_CFG_W-1:0];
					REG_SMOOTHING_SHIFT:  shift_cfg = cfg.data[SHIFT_W-1:0];
					REG_AUTO_ENABLE:      auto_cfg = cfg.data[0];
					default: ;
				endcase
			end

			// compare a panel word with the oldest prediction
			if (panel.valid && panel.ready) begin
				got.write_brightness = panel.write_brightness;
				got.brightness = panel.brightness;
				got.smoothed_level = panel.smoothed_level;
				got.applied_step = panel.applied_step;
				if (panel_words_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected panel word write=%0d level=%0d avg=%0d step=%0d",
						$time, got.write_brightness, got.brightness, got.smoothed_level,
						got.applied_step);
				end else begin
					want = panel_words_due.pop_front();
					if (got.write_brightness !== want.write_brightness) begin
						mismatches++;
						$display("%0t: write_brightness expected %0d actual %0d", $time,
							want.write_brightness, got.write_brightness);
					end
					if (got.brightness !== want.brightness) begin
						mismatches++;
						$display("%0t: brightness expected %0d actual %0d", $time,
							want.brightness, got.brightness);
					end
					if (got.smoothed_level !== want.smoothed_level) begin
						mismatches++;
						$display("%0t: smoothed_level expected %0d actual %0d", $time,
							want.smoothed_level, got.smoothed_level);
					end
					if (got.applied_step !== want.applied_step) begin
						mismatches++;
						$display("%0t: applied_step expected %0d actual %0d", $time,
							want.applied_step, got.applied_step);
					end
				end
			end

			// predict the panel word of each accepted light word
			if (light.valid && light.ready) begin
				seen.sample = light.light_sample;
				seen.sample_valid = light.sample_valid;
				seen.menu_open = light.menu_open;
				seen.elapsed = light.elapsed_ms;
				predict_backlight(seen, want);
				panel_words_due.push_back(want);
			end
			due_cnt = panel_words_due.size();
		end
	end

endmodule

[tb/ambient_light_backlight_stepper_core_tb.sv]
// Top of the backlight stepper testbench: clock, reset, light word stimulus,
// register phases, panel stalls and the verdict.
// Depends on alb_pkg, alb_if.sv, the core and backlight_step_checker.
`timescale 1ns / 1ps

module ambient_light_backlight_stepper_core_tb;
	import alb_pkg::*;

	localparam int SAMPLE_BITS = 12;
	localparam int HOLD_BITS   = 16;
	localparam int IDLE_LIMIT  = 1000;
	localparam int PHASES      = 10;
	localparam int PHASE_WORDS = 113;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	alb_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) light ();
	alb_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) panel ();
	alb_cfg_if cfg ();

	int fail_count;
	int words_due;
	int idle_cycles = 0;
	int burst_left = 0;

	// light generator state
	int light_level = 0;
	int run_left = 0;
	int menu_left = 0;
	bit slow_phase = 1'b0;
	int th_set [4] = '{100, 20, 10, 3};
	int walk_probe [7] = '{0, 3, 4, 10, 11, 21, 101};

	ambient_light_backlight_stepper_core #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.HOLD_BITS(HOLD_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.light(light),
		.panel(panel),
		.cfg(cfg)
	);

	backlight_step_checker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.HOLD_BITS(HOLD_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.light(light),
		.panel(panel),
		.cfg(cfg),
		.fail_count(fail_count),
		.words_due(words_due)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((light.valid && light.ready) || (panel.valid && panel.ready) ||
				(cfg.valid && cfg.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// panel side stalls on a pattern of its own
	initial begin
		int mode;
		int span;
		panel.ready = 1'b0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = (mode == 1) ? $urandom_range(1, 16) : $urandom_range(4, 40);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: panel.ready = 1'b1;
					1: panel.ready = 1'b0;
					2: panel.ready = 1'($urandom_range(0, 1));
					default: panel.ready = ~panel.ready;
				endcase
			end
		end
	end

	// one light word, sent in bursts with random gaps between them
	task automatic send_light(input logic [SAMPLE_BITS-1:0] s, input logic v, input logic m,
		input logic [ELAPSED_W-1:0] e);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				light.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		light.valid = 1'b1;
		light.light_sample = s;
		light.sample_valid = v;
		light.menu_open = m;
		light.elapsed_ms = e;
		@(posedge clk);
		while (!light.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stop sending and let every predicted panel word come out
	task automatic wait_panel_drained();
		light.valid = 1'b0;
		while (words_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// register setting per phase, extremes first and last
	task automatic configure_phase(input int ph);
		int tq [$];
		logic [HOLD_CFG_W-1:0] hold;
		logic [SHIFT_W-1:0] sh;
		logic en;
		tq = {};
		for (int i = 0; i < 4; i++)
			tq.push_back($urandom_range(0, ($urandom_range(0, 1) == 1) ? 4095 : 300));
		if ($urandom_range(0, 3) != 0)
			tq.rsort();
		hold = ($urandom_range(0, 2) == 0) ? HOLD_CFG_W'($urandom_range(0, 1023))
			: HOLD_CFG_W'($urandom_range(0, 3000));
		sh = SHIFT_W'($urandom_range(0, 10));
		en = ($urandom_range(0, 5) != 0);
		slow_phase = 1'b0;
		case (ph)
			0: begin
				tq = {4095, 4095, 4095, 4095};
				hold = '0;
				sh = MAX_SHIFT;
				en = 1'b1;
			end
			1: begin
				// shift drops after a heavy average, so the level clamps
				tq = {0, 0, 0, 0};
				hold = '1;
				sh = 4'd1;
				en = 1'b1;
				slow_phase = 1'b1;
			end
			2: begin
				sh = 4'd15;
				en = 1'b1;
			end
			3: en = 1'b0;
			PHASES - 1: begin
				tq.rsort();
				hold = '1;
				sh = '0;
				en = 1'b1;
				slow_phase = 1'b1;
			end
			default: ;
		endcase
		for (int i = 0; i < 4; i++)
			th_set[i] = tq[i];
		write_reg(REG_THRESHOLD_TOP, {4'($urandom), 12'(tq[0])});
		write_reg(REG_THRESHOLD_SECOND, {4'($urandom), 12'(tq[1])});
		write_reg(REG_THRESHOLD_THIRD, {4'($urandom), 12'(tq[2])});
		write_reg(REG_THRESHOLD_BOTTOM, {4'($urandom), 12'(tq[3])});
		write_reg(REG_HOLD_TIME_MS, hold);
		write_reg(REG_SMOOTHING_SHIFT, {12'($urandom), sh});
		write_reg(REG_AUTO_ENABLE, {15'($urandom), en});
	endtask

	// light runs around a level, with menu visits, dropouts and noise
	task automatic send_random_light();
		int s;
		logic m;
		logic [ELAPSED_W-1:0] e;
		if (run_left == 0) begin
			run_left = slow_phase ? $urandom_range(40, 90) : $urandom_range(3, 30);
			case ($urandom_range(0, 4))
				0: light_level = $urandom_range(0, 15);
				1: light_level = $urandom_range(0, 150);
				2: light_level = th_set[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1;
				default: light_level = $urandom_range(0, 4095);
			endcase
		end
		run_left--;
		if ($urandom_range(0, 7) == 0)
			s = $urandom_range(0, 4095);
		else
			s = light_level + (slow_phase ? 0 : $urandom_range(0, 16) - 8);
		if (s < 0)
			s = 0;
		if (s > 4095)
			s = 4095;
		if (menu_left == 0 && $urandom_range(0, 40) == 0)
			menu_left = $urandom_range(1, 6);
		m = (menu_left > 0);
		if (menu_left > 0)
			menu_left--;
		if (slow_phase)
			e = ELAPSED_W'($urandom_range(900, 1023));
		else begin
			case ($urandom_range(0, 3))
				0: e = ELAPSED_W'($urandom_range(0, 15));
				1: e = 10'd1023;
				default: e = ELAPSED_W'($urandom_range(0, 1023));
			endcase
		end
		send_light(12'(s), ($urandom_range(0, 9) != 0), m, e);
	endtask

	initial begin
		light.valid = 1'b0;
		light.light_sample = '0;
		light.sample_valid = 1'b0;
		light.menu_open = 1'b0;
		light.elapsed_ms = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// before seeding, menu visit while unseeded
		send_light(12'd0, 1'b0, 1'b0, 10'd0);
		send_light(12'd0, 1'b0, 1'b1, 10'd5);
		send_light(12'd0, 1'b0, 1'b1, 10'd0);
		send_light(12'd0, 1'b0, 1'b0, 10'd7);
		// seed at full scale, then hold out the default hold time
		repeat (4) send_light(12'd4095, 1'b1, 1'b0, 10'd1023);
		// menu over a seeded average, exit reapplies at once
		send_light(12'd4095, 1'b1, 1'b1, 10'd0);
		send_light(12'd4095, 1'b1, 1'b0, 10'd0);

		// no hold and no smoothing: walk every threshold edge
		wait_panel_drained();
		write_reg(REG_HOLD_TIME_MS, 16'd0);
		write_reg(REG_SMOOTHING_SHIFT, 16'd0);
		foreach (walk_probe[i])
			repeat (2) send_light(12'(walk_probe[i]), 1'b1, 1'b0, 10'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_panel_drained();
			configure_phase(ph);
			run_left = 0;
			repeat (PHASE_WORDS) send_random_light();
		end

		wait_panel_drained();
		if (fail_count == 0 && words_due == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/alb_pkg.sv
hw/rtl/alb_if.sv
hw/rtl/ambient_light_backlight_stepper_core.sv
tb/backlight_step_checker.sv
tb/ambient_light_backlight_stepper_core_tb.sv
